// ----- design/csl_pkg.sv -----
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the source lexer
// Scan state codes, token kinds, status codes, action and beat types, keyword tables.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int unsigned MaxTokenBytes = 32;
  localparam int unsigned CntW = 6;

  localparam logic [6:0] ST_START  = 7'd0;
  localparam logic [6:0] ST_IDENT  = 7'd1;
  localparam logic [6:0] ST_Z0     = 7'd2;
  localparam logic [6:0] ST_HEX    = 7'd3;
  localparam logic [6:0] ST_BIN    = 7'd4;
  localparam logic [6:0] ST_OCT    = 7'd5;
  localparam logic [6:0] ST_DEC    = 7'd6;
  localparam logic [6:0] ST_FRAC   = 7'd7;
  localparam logic [6:0] ST_EXP    = 7'd8;
  localparam logic [6:0] ST_EXPM   = 7'd9;
  localparam logic [6:0] ST_EXPD   = 7'd10;
  localparam logic [6:0] ST_REL    = 7'd11;
  localparam logic [6:0] ST_BANG   = 7'd12;
  localparam logic [6:0] ST_COLON  = 7'd13;
  localparam logic [6:0] ST_SLASH  = 7'd14;
  localparam logic [6:0] ST_STR    = 7'd15;
  localparam logic [6:0] ST_STRESC = 7'd16;
  localparam logic [6:0] ST_CH0    = 7'd17;
  localparam logic [6:0] ST_CHESC  = 7'd18;
  localparam logic [6:0] ST_CHCL   = 7'd19;
  localparam logic [6:0] ST_CMT    = 7'd20;
  localparam logic [6:0] ST_CSTAR  = 7'd21;
  localparam logic [6:0] ST_CBS    = 7'd22;
  localparam logic [6:0] ST_CCR    = 7'd23;
  localparam logic [6:0] ST_HASH   = 7'd24;
  localparam logic [6:0] ST_PI     = 7'd25;
  localparam logic [6:0] ST_PIF    = 7'd26;
  localparam logic [6:0] ST_PE     = 7'd27;
  localparam logic [6:0] ST_PELSE  = 7'd28;
  localparam logic [6:0] ST_PSP    = 7'd29;
  localparam logic [6:0] ST_INCWS  = 7'd30;
  localparam logic [6:0] ST_INCQ   = 7'd31;
  localparam logic [6:0] ST_INCA   = 7'd32;
  localparam logic [6:0] ST_KW     = 7'd33;
  localparam int unsigned KwLen    = 23;
  localparam logic [6:0] KW_DONE   = 7'd127;

  localparam logic [3:0] TK_NEWLINE = 4'd0;
  localparam logic [3:0] TK_EOF     = 4'd1;
  localparam logic [3:0] TK_IDENT   = 4'd2;
  localparam logic [3:0] TK_NUMBER  = 4'd3;
  localparam logic [3:0] TK_REL     = 4'd4;
  localparam logic [3:0] TK_UNARY   = 4'd5;
  localparam logic [3:0] TK_OPER    = 4'd6;
  localparam logic [3:0] TK_STRING  = 4'd7;
  localparam logic [3:0] TK_CHAR    = 4'd8;
  localparam logic [3:0] TK_PREPROC = 4'd9;
  localparam logic [3:0] TK_COMMENT = 4'd10;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_MALFORM = 2'd1;
  localparam logic [1:0] STS_TOOLONG = 2'd2;
  localparam logic [1:0] STS_UNTERM  = 2'd3;

  typedef enum logic [2:0] {
    OP_SKIP    = 3'd0,
    OP_KEEP    = 3'd1,
    OP_KEEPEND = 3'd2,
    OP_END     = 3'd3,
    OP_ERR     = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] next;
    logic [3:0] kind;
  } act_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] token_byte;
    logic [3:0] token_kind;
    logic [5:0] token_length;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  function automatic logic [7:0] kw_expect(input logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0: r = "e";  5'd1: r = "f";  5'd2: r = "i";  5'd3: r = "n";
      5'd4: r = "e";  5'd5: r = "n";  5'd6: r = "d";  5'd7: r = "e";
      5'd8: r = "f";  5'd9: r = "d";  5'd10: r = "i"; 5'd11: r = "f";
      5'd12: r = "s"; 5'd13: r = "e"; 5'd14: r = "f"; 5'd15: r = "d";
      5'd16: r = "e"; 5'd17: r = "f"; 5'd18: r = "c"; 5'd19: r = "l";
      5'd20: r = "u"; 5'd21: r = "d"; 5'd22: r = "e";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] kw_next(input logic [4:0] i);
    logic [6:0] r;
    unique case (i)
      5'd4, 5'd8, 5'd14: r = ST_PSP;
      5'd11, 5'd17:      r = KW_DONE;
      5'd13:             r = ST_PELSE;
      5'd22:             r = ST_INCWS;
      default:           r = ST_KW + 7'(i) + 7'd1;
    endcase
    return r;
  endfunction

endpackage

// ----- design/csl_if.sv -----
// ----------------------------------------------------------------------------
// csl_in_if, csl_out_if: valid/ready channels
// Each carries one payload beat between a source and a sink.
// ----------------------------------------------------------------------------
interface csl_in_if;
  import csl_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csl_out_if;
  import csl_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/csl_classify.sv -----
// ----------------------------------------------------------------------------
// csl_classify: next-state decode for one byte
// Maps scan state and byte to an action, plus the kind of a state.
// ----------------------------------------------------------------------------
module csl_classify import csl_pkg::*; (
  input  logic [6:0] state_i,
  input  logic [7:0] byte_i,
  output act_t       act_o,
  output logic [3:0] skind_o
);
  logic dig, alp, wrd, hx, spc, pun;
  logic [4:0] ki;

  assign dig = byte_i >= "0" && byte_i <= "9";
  assign alp = (byte_i >= "a" && byte_i <= "z") || (byte_i >= "A" && byte_i <= "Z");
  assign wrd = alp || dig || byte_i == "_";
  assign hx  = dig || (byte_i >= "a" && byte_i <= "f") || (byte_i >= "A" && byte_i <= "F");
  assign spc = byte_i == " " || (byte_i >= 8'd9 && byte_i <= 8'd13);
  assign pun = (byte_i >= 8'd33 && byte_i <= 8'd47) || (byte_i >= 8'd58 && byte_i <= 8'd64)
            || (byte_i >= 8'd91 && byte_i <= 8'd96) || (byte_i >= 8'd123 && byte_i <= 8'd126);
  assign ki  = 5'(state_i - ST_KW);

  function automatic act_t k(input logic [6:0] n);
    return '{op: OP_KEEP, next: n, kind: TK_NEWLINE};
  endfunction
  function automatic act_t f(input logic [3:0] t);
    return '{op: OP_KEEPEND, next: ST_START, kind: t};
  endfunction
  function automatic act_t e(input logic [3:0] t);
    return '{op: OP_END, next: ST_START, kind: t};
  endfunction
  function automatic act_t er();
    return '{op: OP_ERR, next: ST_START, kind: TK_NEWLINE};
  endfunction
  function automatic act_t star(input logic [7:0] c);
    act_t r;
    if (c == "/") r = f(TK_COMMENT);
    else if (c == "*") r = k(ST_CSTAR);
    else if (c == "\\") r = k(ST_CBS);
    else r = k(ST_CMT);
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    c = byte_i;
    act_o = er();
    if (state_i >= ST_KW && state_i < ST_KW + 7'(KwLen)) begin
      if (c != kw_expect(ki)) act_o = er();
      else if (kw_next(ki) == KW_DONE) act_o = f(TK_PREPROC);
      else act_o = k(kw_next(ki));
    end else begin
      unique case (state_i)
        ST_IDENT: act_o = wrd ? k(ST_IDENT) : e(TK_IDENT);
        ST_Z0: begin
          if (c == "x") act_o = k(ST_HEX);
          else if (c == "b") act_o = k(ST_BIN);
          else if (c == "0") act_o = er();
          else if (c >= "1" && c <= "7") act_o = k(ST_OCT);
          else act_o = e(TK_NUMBER);
        end
        ST_HEX: act_o = hx ? k(ST_HEX) : e(TK_NUMBER);
        ST_BIN: act_o = (c == "0" || c == "1") ? k(ST_BIN) : e(TK_NUMBER);
        ST_OCT: act_o = (c >= "0" && c <= "7") ? k(ST_OCT) : e(TK_NUMBER);
        ST_DEC: begin
          if (dig) act_o = k(ST_DEC);
          else if (c == ".") act_o = k(ST_FRAC);
          else if (c == "e" || c == "E") act_o = k(ST_EXP);
          else act_o = e(TK_NUMBER);
        end
        ST_FRAC: begin
          if (dig) act_o = k(ST_FRAC);
          else if (c == "e" || c == "E") act_o = k(ST_EXP);
          else act_o = e(TK_NUMBER);
        end
        ST_EXP: begin
          if (c == "-") act_o = k(ST_EXPM);
          else act_o = dig ? k(ST_EXPD) : er();
        end
        ST_EXPM: act_o = dig ? k(ST_EXPD) : er();
        ST_EXPD: act_o = dig ? k(ST_EXPD) : e(TK_NUMBER);
        ST_REL: act_o = c == "=" ? f(TK_REL) : e(TK_REL);
        ST_BANG: act_o = c == "=" ? f(TK_REL) : e(TK_UNARY);
        ST_COLON: act_o = c == ":" ? f(TK_OPER) : e(TK_OPER);
        ST_SLASH: act_o = c == "*" ? k(ST_CMT) : e(TK_OPER);
        ST_STR: begin
          if (c == "\\") act_o = k(ST_STRESC);
          else act_o = c == "\"" ? f(TK_STRING) : k(ST_STR);
        end
        ST_STRESC: act_o = k(ST_STR);
        ST_CH0: begin
          if (c == "\\") act_o = k(ST_CHESC);
          else act_o = c == "'" ? er() : k(ST_CHCL);
        end
        ST_CHESC: act_o = k(ST_CHCL);
        ST_CHCL: act_o = c == "'" ? f(TK_CHAR) : er();
        ST_CMT: act_o = c == "*" ? k(ST_CSTAR) : k(ST_CMT);
        ST_CSTAR: act_o = star(c);
        ST_CBS: begin
          if (c == 8'd10 || c == "*") act_o = k(ST_CSTAR);
          else if (c == 8'd13) act_o = k(ST_CCR);
          else act_o = k(ST_CMT);
        end
        ST_CCR: act_o = c == 8'd10 ? k(ST_CSTAR) : star(c);
        ST_HASH: begin
          if (c == "i") act_o = k(ST_PI);
          else if (c == "d") act_o = k(ST_KW);
          else if (c == "u") act_o = k(ST_KW + 7'd5);
          else if (c == "e") act_o = k(ST_PE);
          else act_o = er();
        end
        ST_PI: begin
          if (c == "f") act_o = k(ST_PIF);
          else act_o = c == "n" ? k(ST_KW + 7'd18) : er();
        end
        ST_PIF: begin
          if (c == " ") act_o = e(TK_PREPROC);
          else if (c == "n") act_o = k(ST_KW + 7'd15);
          else act_o = c == "d" ? k(ST_KW + 7'd16) : er();
        end
        ST_PE: begin
          if (c == "n") act_o = k(ST_KW + 7'd9);
          else act_o = c == "l" ? k(ST_KW + 7'd12) : er();
        end
        ST_PELSE: begin
          if (spc) act_o = e(TK_PREPROC);
          else act_o = c == "i" ? k(ST_KW + 7'd14) : er();
        end
        ST_PSP: act_o = c == " " ? e(TK_PREPROC) : er();
        ST_INCWS: begin
          if (spc) act_o = k(ST_INCWS);
          else if (c == "\"") act_o = k(ST_INCQ);
          else act_o = c == "<" ? k(ST_INCA) : er();
        end
        ST_INCQ: act_o = c == "\"" ? f(TK_PREPROC) : k(ST_INCQ);
        ST_INCA: act_o = c == ">" ? f(TK_PREPROC) : k(ST_INCA);
        default: begin
          if (c == 8'd10) act_o = f(TK_NEWLINE);
          else if (spc) act_o = '{op: OP_SKIP, next: ST_START, kind: TK_NEWLINE};
          else if (alp || c == "_") act_o = k(ST_IDENT);
          else if (c == "0") act_o = k(ST_Z0);
          else if (dig) act_o = k(ST_DEC);
          else if (c == "<" || c == "=" || c == ">") act_o = k(ST_REL);
          else if (c == "!") act_o = k(ST_BANG);
          else if (c == ":") act_o = k(ST_COLON);
          else if (c == "\"") act_o = k(ST_STR);
          else if (c == "'") act_o = k(ST_CH0);
          else if (c == "#") act_o = k(ST_HASH);
          else if (c == "/") act_o = k(ST_SLASH);
          else if (pun) act_o = f(TK_OPER);
          else act_o = er();
        end
      endcase
    end
  end

  always_comb begin
    if (state_i == ST_IDENT) skind_o = TK_IDENT;
    else if (state_i >= ST_Z0 && state_i <= ST_EXPD) skind_o = TK_NUMBER;
    else if (state_i == ST_REL) skind_o = TK_REL;
    else if (state_i == ST_BANG) skind_o = TK_UNARY;
    else if (state_i == ST_COLON || state_i == ST_SLASH) skind_o = TK_OPER;
    else if (state_i == ST_STR || state_i == ST_STRESC) skind_o = TK_STRING;
    else if (state_i >= ST_CH0 && state_i <= ST_CHCL) skind_o = TK_CHAR;
    else if (state_i >= ST_CMT && state_i <= ST_CCR) skind_o = TK_COMMENT;
    else if (state_i >= ST_HASH && state_i < ST_KW + 7'(KwLen)) skind_o = TK_PREPROC;
    else skind_o = TK_NEWLINE;
  end
endmodule

// ----- design/csl_fifo.sv -----
// ----------------------------------------------------------------------------
// csl_fifo: result beat queue
// Small register queue that parts the scan from the output handshake.
// ----------------------------------------------------------------------------
module csl_fifo import csl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t [2:0] push_i,
  output logic [3:0] free_o,
  csl_out_if.source  out
);
  localparam int unsigned Depth = 8;
  res_t       mem_q [Depth];
  logic [2:0] rd_q, wr_q;
  logic [3:0] cnt_q;
  logic       pop;

  assign pop       = out.valid && out.ready;
  assign out.valid = cnt_q != 4'd0;
  assign out.data  = mem_q[rd_q];
  assign free_o    = 4'(Depth) - cnt_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n_i) mem_q[wr_q + 3'(i)] <= push_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + 3'(push_n_i);
      rd_q  <= rd_q + 3'(pop);
      cnt_q <= cnt_q + 4'(push_n_i) - 4'(pop);
    end
  end
endmodule

// ----- design/c_style_source_lexer_unit.sv -----
// ----------------------------------------------------------------------------
// c_style_source_lexer_unit: byte-serial C-style lexer
// Echoes kept bytes and emits token-end markers with kind, length, status.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, from which its
//   results are written into the output queue; the queue presents its
//   head beat combinationally.
// Throughput: one byte per cycle while the queue keeps six slots free; each
//   byte makes up to three result beats; the output port sends one per cycle.
// Reset: async active low; scan state to start, token count and queue empty.
module c_style_source_lexer_unit import csl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  csl_in_if.sink    in_i,
  csl_out_if.source out_o
);
  // input register
  logic       v_q;
  in_t        in_q;
  logic [6:0] st_q, st_d;
  logic [5:0] cnt_q, cnt_d;
  logic [3:0] free;
  logic       go;
  res_t [2:0] res;
  logic [1:0] n;

  // Take a byte only when the queue can absorb three beats beyond the held one.
  assign in_i.ready = free >= 4'd6;
  assign go = v_q;

  act_t       a1, a2, ae;
  logic [3:0] k1, k2, ke;
  logic [6:0] s2;

  csl_classify u_c1 (.state_i(st_q), .byte_i(in_q.data_byte), .act_o(a1), .skind_o(k1));
  csl_classify u_c2 (.state_i(s2), .byte_i(in_q.data_byte), .act_o(a2), .skind_o(k2));
  csl_classify u_ce (.state_i(st_q), .byte_i(8'h20), .act_o(ae), .skind_o(ke));

  // The second pass always starts from the start state with zero count.
  assign s2 = ST_START;

  function automatic res_t mark(input logic [3:0] t, input logic [5:0] l,
                                input logic [1:0] s);
    return '{kind: 1'b1, token_byte: 8'd0, token_kind: t, token_length: l,
             status: s, last: 1'b0};
  endfunction

  always_comb begin
    logic rerun;
    res   = '0;
    n     = 2'd0;
    st_d  = st_q;
    cnt_d = cnt_q;
    rerun = 1'b0;
    if (in_q.end_of_input) begin
      if (st_q != ST_START) begin
        res[0] = ae.op == OP_END ? mark(ae.kind, cnt_q, STS_OK)
                                 : mark(ke, cnt_q, STS_UNTERM);
        res[1] = mark(TK_EOF, 6'd0, STS_OK);
        n = 2'd2;
      end else begin
        res[0] = mark(TK_EOF, 6'd0, STS_OK);
        n = 2'd1;
      end
      st_d = ST_START; cnt_d = '0;
    end else begin
      // first pass from the held state
      unique case (a1.op)
        OP_SKIP: ;
        OP_KEEP, OP_KEEPEND: begin
          if (cnt_q >= 6'(MaxTokenBytes)) begin
            res[0] = mark(k1, cnt_q, STS_TOOLONG);
            n = 2'd1; rerun = 1'b1;
          end else begin
            res[0] = '{kind: 1'b0, token_byte: in_q.data_byte, token_kind: TK_NEWLINE,
                       token_length: 6'd0, status: STS_OK, last: 1'b0};
            if (a1.op == OP_KEEPEND) begin
              res[1] = mark(a1.kind, cnt_q + 6'd1, STS_OK);
              n = 2'd2; st_d = ST_START; cnt_d = '0;
            end else begin
              n = 2'd1; st_d = a1.next; cnt_d = cnt_q + 6'd1;
            end
          end
        end
        OP_END: begin
          res[0] = mark(a1.kind, cnt_q, STS_OK);
          n = 2'd1; rerun = 1'b1;
        end
        default: begin
          res[0] = mark(k1, cnt_q, STS_MALFORM);
          n = 2'd1; st_d = ST_START; cnt_d = '0;
          rerun = st_q != ST_START;
        end
      endcase
      // second pass from the start state
      if (rerun) begin
        st_d = ST_START; cnt_d = '0;
        unique case (a2.op)
          OP_SKIP: ;
          OP_KEEP, OP_KEEPEND: begin
            res[1] = '{kind: 1'b0, token_byte: in_q.data_byte, token_kind: TK_NEWLINE,
                       token_length: 6'd0, status: STS_OK, last: 1'b0};
            if (a2.op == OP_KEEPEND) begin
              res[2] = mark(a2.kind, 6'd1, STS_OK);
              n = 2'd3;
            end else begin
              n = 2'd2; st_d = a2.next; cnt_d = 6'd1;
            end
          end
          OP_END: begin
            res[1] = mark(a2.kind, 6'd0, STS_OK);
            n = 2'd2;
          end
          default: begin
            res[1] = mark(k2, 6'd0, STS_MALFORM);
            n = 2'd2;
          end
        endcase
      end
    end
    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
    if (!go) n = 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      st_q  <= ST_START;
      cnt_q <= '0;
    end else begin
      v_q <= in_i.valid && in_i.ready;
      if (go) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
    end
  end

  csl_fifo u_fifo (
    .clk_i, .rst_ni, .push_n_i(n), .push_i(res), .free_o(free), .out(out_o)
  );
endmodule
